// ----- rtl/rrbc_pkg.sv -----
// Shared types and constants for the cartridge ROM/RAM bank controller.
`default_nettype none

package rrbc_pkg;

  // Default width of the ROM bank register
  localparam int ROM_BANK_BITS_DEF = 7;

  // Controller type codes
  localparam logic [1:0] CTRL_NONE  = 2'd0;
  localparam logic [1:0] CTRL_TYPE1 = 2'd1;
  localparam logic [1:0] CTRL_TYPE2 = 2'd2;
  localparam logic [1:0] CTRL_TYPE3 = 2'd3;

  // Target codes
  localparam logic [1:0] TGT_FIXED_ROM  = 2'd0;
  localparam logic [1:0] TGT_BANKED_ROM = 2'd1;
  localparam logic [1:0] TGT_EXT_RAM    = 2'd2;
  localparam logic [1:0] TGT_NONE       = 2'd3;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Register windows in address bits 14:13 of the lower 32K
  localparam logic [1:0] WIN_RAM_EN   = 2'd0;
  localparam logic [1:0] WIN_ROM_BANK = 2'd1;
  localparam logic [1:0] WIN_UPPER    = 2'd2;
  localparam logic [1:0] WIN_MODE     = 2'd3;

  // Data codes
  localparam logic [3:0] RAM_EN_CODE  = 4'hA;
  localparam logic [7:0] RAM_BANK_MAX = 8'h03;
  localparam logic [7:0] RTC_SEL_LO   = 8'h08;
  localparam logic [7:0] RTC_SEL_HI   = 8'h0C;
  localparam logic [15:0] TYPE1_KEEP_MASK = 16'd224;
  localparam logic [15:0] TYPE1_LOW_MASK  = 16'd31;
  localparam logic [15:0] TYPE3_MASK      = 16'h007F;
  localparam logic [15:0] TYPE2_MASK      = 16'h000F;

  typedef struct packed {
    logic        func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] rom_address;
    logic [1:0]  ram_bank;
    logic [12:0] ram_offset;
    logic        ram_enabled;
    logic        rtc_selected;
  } out_t;

  // Small bank state seen after the current access
  typedef struct packed {
    logic [1:0] ram_bank;
    logic       ram_enable;
    logic       rtc_select;
  } bank_state_t;

  // Bank number from a written byte: zero becomes one, then mask
  function automatic logic [15:0] bank_from_byte(input logic [7:0] d,
                                                 input logic [15:0] mask);
    logic [15:0] v;
    v = (d == 8'd0) ? 16'd1 : {8'd0, d};
    return v & mask;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rrbc_bank_regs.sv -----
// Bank registers and controller type, with their write decode.
`default_nettype none

module rrbc_bank_regs #(
  parameter int ROM_BANK_BITS = rrbc_pkg::ROM_BANK_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_wdata,
  input  wire logic                     take,
  input  wire rrbc_pkg::in_t            item,
  output logic [ROM_BANK_BITS-1:0]      rom_bank_after,
  output rrbc_pkg::bank_state_t         state_after
);
  import rrbc_pkg::*;

  logic [1:0]               controller_type;
  logic [ROM_BANK_BITS-1:0] rom_bank;
  logic [ROM_BANK_BITS-1:0] rom_bank_next;
  logic [1:0]               ram_bank;
  logic [1:0]               ram_bank_next;
  logic                     rom_mode;
  logic                     rom_mode_next;
  logic                     ram_enable;
  logic                     ram_enable_next;
  logic                     rtc_select;
  logic                     rtc_select_next;
  logic [15:0]              bank_wide;
  logic [15:0]              up;
  logic                     wr;

  assign bank_wide = 16'(rom_bank);
  assign wr = (item.func == FUNC_WRITE) && (controller_type != CTRL_NONE) &&
              !item.address[15];

  // Decode register writes in the lower 32K
  always_comb begin
    rom_bank_next   = rom_bank;
    ram_bank_next   = ram_bank;
    rom_mode_next   = rom_mode;
    ram_enable_next = ram_enable;
    rtc_select_next = rtc_select;
    up              = 16'({14'd0, item.write_data[1:0]} << 5);
    if (wr) begin
      unique case (item.address[14:13])
        WIN_RAM_EN: begin
          if (!(controller_type == CTRL_TYPE2 && item.address[8])) begin
            if (item.write_data[3:0] == RAM_EN_CODE) begin
              ram_enable_next = 1'b1;
            end else if (item.write_data == 8'd0) begin
              ram_enable_next = 1'b0;
            end
          end
        end
        WIN_ROM_BANK: begin
          if (controller_type == CTRL_TYPE1) begin
            rom_bank_next = ROM_BANK_BITS'((bank_wide & TYPE1_KEEP_MASK) |
                            bank_from_byte(item.write_data, TYPE1_LOW_MASK));
          end else if (controller_type == CTRL_TYPE3) begin
            rom_bank_next = ROM_BANK_BITS'(bank_from_byte(item.write_data, TYPE3_MASK));
          end else begin
            rom_bank_next = ROM_BANK_BITS'(bank_from_byte(item.write_data, TYPE2_MASK));
          end
        end
        WIN_UPPER: begin
          if (controller_type == CTRL_TYPE3) begin
            if (item.write_data <= RAM_BANK_MAX) begin
              ram_bank_next   = item.write_data[1:0];
              rtc_select_next = 1'b0;
            end else if (item.write_data >= RTC_SEL_LO &&
                         item.write_data <= RTC_SEL_HI) begin
              rtc_select_next = 1'b1;
            end
          end else if (controller_type == CTRL_TYPE1) begin
            if (rom_mode) begin
              ram_bank_next = 2'd0;
              if ((bank_wide & TYPE1_LOW_MASK) == 16'd0) begin
                up = up + 16'd1;
              end
              rom_bank_next = ROM_BANK_BITS'((bank_wide & TYPE1_LOW_MASK) | up);
            end else begin
              ram_bank_next = item.write_data[1:0];
            end
          end
        end
        WIN_MODE: begin
          if (controller_type == CTRL_TYPE1) begin
            if (item.write_data[0]) begin
              ram_bank_next = 2'd0;
              rom_mode_next = 1'b0;
            end else begin
              rom_mode_next = 1'b1;
            end
          end
        end
        default: begin
          rom_mode_next = rom_mode;
        end
      endcase
    end
  end

  // Hold state; the controller type loads on cfg_we and the bank registers advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      controller_type <= CTRL_NONE;
      rom_bank        <= ROM_BANK_BITS'(1);
      ram_bank        <= 2'd0;
      rom_mode        <= 1'b1;
      ram_enable      <= 1'b0;
      rtc_select      <= 1'b0;
    end else begin
      if (cfg_we) begin
        controller_type <= cfg_wdata;
      end
      if (take) begin
        rom_bank   <= rom_bank_next;
        ram_bank   <= ram_bank_next;
        rom_mode   <= rom_mode_next;
        ram_enable <= ram_enable_next;
        rtc_select <= rtc_select_next;
      end
    end
  end

  assign rom_bank_after         = rom_bank_next;
  assign state_after.ram_bank   = ram_bank_next;
  assign state_after.ram_enable = ram_enable_next;
  assign state_after.rtc_select = rtc_select_next;

endmodule

`default_nettype wire

// ----- rtl/rom_ram_bank_controller_unit.sv -----
// Top level of the cartridge ROM/RAM bank controller: handshake and result register.
// The result of a transaction is registered and valid in the cycle after it is accepted.
// One transaction per cycle while results are taken; the result register is the only stage.
// The input side stalls only while a result waits and the output side is not ready.
// Reset (rst, synchronous): controller type 0, ROM bank 1, RAM bank 0, ROM mode 1,
// RAM and clock select disabled, no result pending.
`default_nettype none

module rom_ram_bank_controller_unit #(
  parameter int ROM_BANK_BITS = rrbc_pkg::ROM_BANK_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_wdata,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rrbc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rrbc_pkg::out_t      out_data
);
  import rrbc_pkg::*;

  logic                     take;
  logic [ROM_BANK_BITS-1:0] rom_bank_after;
  bank_state_t              state_after;
  out_t                     result_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  rrbc_bank_regs #(
    .ROM_BANK_BITS(ROM_BANK_BITS)
  ) u_bank_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .take           (take),
    .item           (in_data),
    .rom_bank_after (rom_bank_after),
    .state_after    (state_after)
  );

  // Translate the address with the bank state after this access
  always_comb begin
    result_next.rom_address  = 21'd0;
    result_next.ram_offset   = 13'd0;
    result_next.ram_bank     = state_after.ram_bank;
    result_next.ram_enabled  = state_after.ram_enable;
    result_next.rtc_selected = state_after.rtc_select;
    if (in_data.address[15:14] == 2'b00) begin
      result_next.target      = TGT_FIXED_ROM;
      result_next.rom_address = 21'(in_data.address);
    end else if (in_data.address[15:14] == 2'b01) begin
      result_next.target      = TGT_BANKED_ROM;
      result_next.rom_address = 21'({rom_bank_after, in_data.address[13:0]});
    end else if (in_data.address[15:13] == 3'b101) begin
      result_next.target     = TGT_EXT_RAM;
      result_next.ram_offset = in_data.address[12:0];
    end else begin
      result_next.target = TGT_NONE;
    end
  end

  // Hold the result until taken; load on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- bench/tb_rom_ram_bank_controller_unit.sv -----
// Testbench for the cartridge ROM/RAM bank controller: directed and random bus accesses.
`timescale 1ns / 100ps

module tb_rom_ram_bank_controller_unit;
  import rrbc_pkg::*;

  localparam int BANK_W = ROM_BANK_BITS_DEF;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = 2'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Bank register mirror, updated per accepted transaction
  logic [1:0] cur_type;
  logic [BANK_W-1:0] rom_bank_q;
  logic [1:0] ram_bank_q;
  logic rom_mode_q;
  logic ram_en_q;
  logic rtc_sel_q;

  out_t pending_maps[$];
  out_t want;
  int errors = 0;
  logic gaps_on = 1'b1;
  int ready_hold = 0;

  rom_ram_bank_controller_unit #(
    .ROM_BANK_BITS(BANK_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #10_000_000;
    $display("tb_rom_ram_bank_controller_unit: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void reset_banks();
    cur_type = CTRL_NONE;
    rom_bank_q = BANK_W'(1);
    ram_bank_q = 2'd0;
    rom_mode_q = 1'b1;
    ram_en_q = 1'b0;
    rtc_sel_q = 1'b0;
  endfunction

  // Apply one bus access to the bank mirror and translate its address
  function automatic out_t map_access(in_t acc);
    out_t r;
    logic [15:0] a;
    logic [7:0] d;
    logic [7:0] nz;
    logic [BANK_W-1:0] up;
    a = acc.address;
    d = acc.write_data;
    nz = (d == 8'd0) ? 8'd1 : d;
    if (acc.func == FUNC_WRITE && cur_type != CTRL_NONE && !a[15]) begin
      case (a[14:13])
        WIN_RAM_EN: begin
          if (!(cur_type == CTRL_TYPE2 && a[8])) begin
            if (d[3:0] == RAM_EN_CODE) ram_en_q = 1'b1;
            else if (d == 8'd0) ram_en_q = 1'b0;
          end
        end
        WIN_ROM_BANK: begin
          if (cur_type == CTRL_TYPE1) rom_bank_q = {rom_bank_q[BANK_W-1:5], nz[4:0]};
          else if (cur_type == CTRL_TYPE3) rom_bank_q = BANK_W'(nz & 8'h7F);
          else rom_bank_q = BANK_W'(nz & 8'h0F);
        end
        WIN_UPPER: begin
          if (cur_type == CTRL_TYPE3) begin
            if (d <= RAM_BANK_MAX) begin
              ram_bank_q = d[1:0];
              rtc_sel_q = 1'b0;
            end else if (d >= RTC_SEL_LO && d <= RTC_SEL_HI) begin
              rtc_sel_q = 1'b1;
            end
          end else if (cur_type == CTRL_TYPE1) begin
            if (rom_mode_q) begin
              // upper ROM bits; a zero low part steps to the next bank
              up = BANK_W'(d[1:0]) << 5;
              ram_bank_q = 2'd0;
              if (rom_bank_q[4:0] == 5'd0) up = up + BANK_W'(1);
              rom_bank_q = BANK_W'(rom_bank_q[4:0]) | up;
            end else begin
              ram_bank_q = d[1:0];
            end
          end
        end
        default: begin
          if (cur_type == CTRL_TYPE1) begin
            if (d[0]) begin
              ram_bank_q = 2'd0;
              rom_mode_q = 1'b0;
            end else begin
              rom_mode_q = 1'b1;
            end
          end
        end
      endcase
    end
    r = '0;
    if (a < 16'h4000) begin
      r.target = TGT_FIXED_ROM;
      r.rom_address = 21'(a);
    end else if (a < 16'h8000) begin
      r.target = TGT_BANKED_ROM;
      r.rom_address = 21'({rom_bank_q, a[13:0]});
    end else if (a >= 16'hA000 && a < 16'hC000) begin
      r.target = TGT_EXT_RAM;
      r.ram_offset = a[12:0];
    end else begin
      r.target = TGT_NONE;
    end
    r.ram_bank = ram_bank_q;
    r.ram_enabled = ram_en_q;
    r.rtc_selected = rtc_sel_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [20:0] exp_v, logic [20:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: result with none expected, got %p", $time, out_data);
        errors++;
      end else begin
        want = pending_maps.pop_front();
        check_field("target", 21'(want.target), 21'(out_data.target));
        check_field("rom_address", want.rom_address, out_data.rom_address);
        check_field("ram_bank", 21'(want.ram_bank), 21'(out_data.ram_bank));
        check_field("ram_offset", 21'(want.ram_offset), 21'(out_data.ram_offset));
        check_field("ram_enabled", 21'(want.ram_enabled), 21'(out_data.ram_enabled));
        check_field("rtc_selected", 21'(want.rtc_selected),
                    21'(out_data.rtc_selected));
      end
    end
  end

  // Stall the result side at random, holding each choice for a while
  initial begin
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        ready_hold--;
      end else if (!gaps_on || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b0;
        ready_hold = pick_gap();
      end
    end
  end

  // Present one access; entered and left just after a falling edge
  task automatic send_access(input in_t acc);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= acc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_maps.push_back(map_access(acc));
    @(negedge clk);
  endtask

  task automatic bus(input logic f, input logic [15:0] a, input logic [7:0] d);
    in_t acc;
    acc.func = f;
    acc.address = a;
    acc.write_data = d;
    send_access(acc);
  endtask

  // Drop valid and wait for every prediction to be matched
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_type(input logic [1:0] t);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_type = t;
  endtask

  function automatic in_t rand_access();
    in_t acc;
    int pick;
    acc.func = ($urandom_range(0, 99) < 60) ? FUNC_WRITE : FUNC_READ;
    pick = $urandom_range(0, 9);
    if (acc.func == FUNC_WRITE && pick < 8) acc.address = {1'b0, 15'($urandom)};
    else if (pick < 5) acc.address = {2'b01, 14'($urandom)};
    else if (pick < 7) acc.address = {3'b101, 13'($urandom)};
    else acc.address = 16'($urandom);
    case ($urandom_range(0, 9))
      0: acc.write_data = 8'd0;
      1: acc.write_data = {4'($urandom), RAM_EN_CODE};
      2: acc.write_data = 8'($urandom_range(0, 3));
      3: acc.write_data = 8'($urandom_range(8, 12));
      4: acc.write_data = 8'($urandom_range(0, 15));
      5: acc.write_data = {3'($urandom), 5'd0};
      default: acc.write_data = 8'($urandom);
    endcase
    return acc;
  endfunction

  // No banking: fixed ROM, unmapped and external RAM reads decode, writes change nothing
  task automatic test_no_banking();
    set_type(CTRL_NONE);
    bus(FUNC_READ, 16'h3FFF, 8'h00);
    bus(FUNC_READ, 16'h9FFF, 8'hFF);
    bus(FUNC_READ, 16'hA000, 8'h00);
    bus(FUNC_READ, 16'hBFFF, 8'h00);
    bus(FUNC_WRITE, 16'h0000, 8'h0A);
    bus(FUNC_WRITE, 16'h2000, 8'h05);
  endtask

  task automatic test_type1();
    set_type(CTRL_TYPE1);
    bus(FUNC_WRITE, 16'h1FFF, 8'hFA);
    bus(FUNC_WRITE, 16'h0000, 8'h05);
    bus(FUNC_WRITE, 16'h2000, 8'h00);
    // nonzero byte whose low five bits are zero
    bus(FUNC_WRITE, 16'h3FFF, 8'h20);
    bus(FUNC_WRITE, 16'h4000, 8'h02);
    bus(FUNC_WRITE, 16'h6000, 8'h01);
    bus(FUNC_WRITE, 16'h5FFF, 8'h03);
    bus(FUNC_WRITE, 16'h7FFF, 8'hFE);
    bus(FUNC_WRITE, 16'h0000, 8'h00);
    bus(FUNC_WRITE, 16'hA000, 8'hFF);
  endtask

  task automatic test_type2();
    set_type(CTRL_TYPE2);
    bus(FUNC_WRITE, 16'h0100, 8'h0A);
    bus(FUNC_WRITE, 16'h1EFF, 8'h0A);
    bus(FUNC_WRITE, 16'h2000, 8'hFF);
    bus(FUNC_WRITE, 16'h2100, 8'h10);
    bus(FUNC_WRITE, 16'h4000, 8'h03);
    bus(FUNC_WRITE, 16'h6000, 8'h01);
  endtask

  task automatic test_type3();
    set_type(CTRL_TYPE3);
    bus(FUNC_WRITE, 16'h2000, 8'h00);
    bus(FUNC_WRITE, 16'h3000, 8'hFF);
    bus(FUNC_WRITE, 16'h4000, 8'h03);
    bus(FUNC_WRITE, 16'h4000, 8'h08);
    bus(FUNC_WRITE, 16'h5000, 8'h0C);
    bus(FUNC_WRITE, 16'h4000, 8'h05);
    bus(FUNC_WRITE, 16'h4000, 8'h0D);
    bus(FUNC_WRITE, 16'h4000, 8'h00);
    bus(FUNC_WRITE, 16'h6000, 8'h01);
    bus(FUNC_WRITE, 16'h2000, 8'h80);
  endtask

  // Random accesses under each controller type; each phase opens without gaps
  task automatic test_random();
    logic [1:0] phase_types[5];
    phase_types = '{CTRL_TYPE1, CTRL_TYPE3, CTRL_TYPE2, CTRL_NONE, CTRL_TYPE1};
    foreach (phase_types[p]) begin
      set_type(phase_types[p]);
      for (int i = 0; i < 200; i++) begin
        gaps_on = (i >= 50);
        send_access(rand_access());
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    reset_banks();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_no_banking();
    test_type1();
    test_type2();
    test_type3();
    test_random();
    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_rom_ram_bank_controller_unit: done, clean");
    end else begin
      $display("tb_rom_ram_bank_controller_unit: done, errors");
    end
    $finish;
  end

endmodule
